// File: rtl/rbi_pkg.sv
// Package for the ray/box intersection core: widths, axis classes and the
// words passed between pipeline stages. No dependencies.
`default_nettype none
package rbi_pkg;
    localparam int CW = 32;
    localparam int FB = 16;
    localparam int DW = CW + FB;
    localparam int NAX = 3;
    localparam int AXW = 2;

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [1:0] {
        AX_BELOW  = 2'd0,
        AX_ABOVE  = 2'd1,
        AX_INSIDE = 2'd2
    } axcls_t;

    // Saturation limits of the coordinate range.
    localparam logic signed [CW-1:0] HI_LIM = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] LO_LIM = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] MINUS_ONE = -(CW'(1) <<< FB);

    // Per-lane division request.
    typedef struct packed {
        logic          en;
        logic          neg;
        logic [CW:0]   dm;
        logic [CW-1:0] dv;
    } div_req_t;
endpackage
`default_nettype wire

// File: rtl/rbi_div_lane.sv
// One pipelined restoring divider lane: t = floor(+-dm*2^F/dv), saturated.
// One quotient bit per stage. Depends on rbi_pkg.
`default_nettype none
module rbi_div_lane (
    input  wire logic              clk,
    input  wire rbi_pkg::div_req_t req,
    output rbi_pkg::coord_t        t
);
    import rbi_pkg::*;

    localparam int NST = DW + 1;

    logic [DW:0]   num_reg  [NST+1];
    logic [CW:0]   rem_reg  [NST+1];
    logic [DW:0]   q_reg    [NST+1];
    logic [CW-1:0] dv_reg   [NST+1];
    logic          neg_reg  [NST+1];
    logic          en_reg   [NST+1];

    // Load stage: numerator is dm shifted left by the fraction bits.
    always_ff @(posedge clk)
    begin
        num_reg[0] <= {req.dm, {FB{1'b0}}};
        rem_reg[0] <= '0;
        q_reg[0]   <= '0;
        dv_reg[0]  <= req.dv;
        neg_reg[0] <= req.neg;
        en_reg[0]  <= req.en;
    end

    // One quotient bit per stage.
    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [CW+1:0] r_sh;
        logic          ge;
        always_comb
        begin
            r_sh = {rem_reg[s], num_reg[s][DW]};
            ge   = r_sh >= {2'b00, dv_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            num_reg[s+1] <= num_reg[s] << 1;
            rem_reg[s+1] <= ge ? (CW+1)'(r_sh - {2'b00, dv_reg[s]}) : r_sh[CW:0];
            q_reg[s+1]   <= {q_reg[s][DW-1:0], ge};
            dv_reg[s+1]  <= dv_reg[s];
            neg_reg[s+1] <= neg_reg[s];
            en_reg[s+1]  <= en_reg[s];
        end
    end

    // Floor correction and saturation.
    always_comb
    begin
        logic [DW+1:0] q;
        logic [DW+1:0] cap;
        q   = {1'b0, q_reg[NST]} + {{(DW+1){1'b0}},
              (neg_reg[NST] && rem_reg[NST] != '0)};
        cap = neg_reg[NST] ? (DW+2)'({1'b1, {(CW-1){1'b0}}})
                           : (DW+2)'({1'b0, {(CW-1){1'b1}}});
        if (q > cap)
            q = cap;
        if (!en_reg[NST])
            t = MINUS_ONE;
        else if (neg_reg[NST])
            t = CW'(-q);
        else
            t = q[CW-1:0];
    end
endmodule
`default_nettype wire

// File: rtl/ray_box_intersection_core.sv
// Ray / axis-aligned box intersection, three divider lanes and a merge stage.
// Depends on rbi_pkg and rbi_div_lane.
//
//  channel | handshake        | ports
//  input   | start & !busy    | origin_*, direction_*, box_low_*, box_high_*
//  result  | done strobe      | hit, point_x, point_y, point_z
//
// One ray enters per cycle; busy is always low. Stages in order:
// classify, divider lanes, pick, multiply, scale, add and test. The
// result word is shown for one cycle on done; the receiver cannot
// stall. rst_n clears the valid pipeline only.
`default_nettype none
module ray_box_intersection_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire rbi_pkg::coord_t      origin_x,
    input  wire rbi_pkg::coord_t      origin_y,
    input  wire rbi_pkg::coord_t      origin_z,
    input  wire rbi_pkg::coord_t      direction_x,
    input  wire rbi_pkg::coord_t      direction_y,
    input  wire rbi_pkg::coord_t      direction_z,
    input  wire rbi_pkg::coord_t      box_low_x,
    input  wire rbi_pkg::coord_t      box_low_y,
    input  wire rbi_pkg::coord_t      box_low_z,
    input  wire rbi_pkg::coord_t      box_high_x,
    input  wire rbi_pkg::coord_t      box_high_y,
    input  wire rbi_pkg::coord_t      box_high_z,
    output logic                      done,
    output logic                      hit,
    output rbi_pkg::coord_t           point_x,
    output rbi_pkg::coord_t           point_y,
    output rbi_pkg::coord_t           point_z
);
    import rbi_pkg::*;

    localparam int DL  = DW + 3;  // context depth: classify plus the divider lanes
    localparam int LAT = DL + 4;

    // Context carried alongside the dividers.
    typedef struct packed {
        logic        in_box;
        coord_t [NAX-1:0] org;
        coord_t [NAX-1:0] dir;
        coord_t [NAX-1:0] lo;
        coord_t [NAX-1:0] hi;
        coord_t [NAX-1:0] plane;
    } ctx_t;

    coord_t   org_w [NAX], dir_w [NAX], lo_w [NAX], hi_w [NAX];
    logic     vld_reg [LAT];
    ctx_t     ctx_reg [DL];
    div_req_t req_reg [NAX];
    coord_t   t_w [NAX];

    assign busy = 1'b0;
    assign org_w = '{origin_x, origin_y, origin_z};
    assign dir_w = '{direction_x, direction_y, direction_z};
    assign lo_w  = '{box_low_x, box_low_y, box_low_z};
    assign hi_w  = '{box_high_x, box_high_y, box_high_z};

    // Valid pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Classify each axis and build the divide requests.
    always_ff @(posedge clk)
    begin
        ctx_t c;
        c.in_box = 1'b1;
        for (int a = 0; a < NAX; a++)
        begin
            logic blw, abv;
            blw = org_w[a] < lo_w[a];
            abv = !blw && org_w[a] > hi_w[a];
            c.org[a] = org_w[a];
            c.dir[a] = dir_w[a];
            c.lo[a]  = lo_w[a];
            c.hi[a]  = hi_w[a];
            c.plane[a] = blw ? lo_w[a] : (abv ? hi_w[a] : '0);
            if (blw || abv)
                c.in_box = 1'b0;
            req_reg[a].en  <= (blw || abv) && dir_w[a] != '0;
            req_reg[a].neg <= abv ^ dir_w[a][CW-1];
            req_reg[a].dm  <= blw
                ? (CW+1)'({lo_w[a][CW-1], lo_w[a]} - {org_w[a][CW-1], org_w[a]})
                : (CW+1)'({org_w[a][CW-1], org_w[a]} - {hi_w[a][CW-1], hi_w[a]});
            req_reg[a].dv  <= dir_w[a][CW-1] ? CW'(-dir_w[a]) : dir_w[a];
        end
        ctx_reg[0] <= c;
        for (int i = 1; i < DL; i++)
            ctx_reg[i] <= ctx_reg[i-1];
    end

    for (genvar a = 0; a < NAX; a++) begin : g_lane
        rbi_div_lane u_div (
            .clk   (clk),
            .req   (req_reg[a]),
            .t     (t_w[a])
        );
    end

    // Merge: pick the largest distance, first axis on ties.
    logic [AXW-1:0] best_reg;
    coord_t         tb_reg;
    ctx_t           c1_reg, c2_reg, c3_reg, c4_reg;
    always_ff @(posedge clk)
    begin
        logic [AXW-1:0] b;
        coord_t tb;
        b = '0;
        tb = t_w[0];
        for (int a = 1; a < NAX; a++)
            if (tb < t_w[a])
            begin
                tb = t_w[a];
                b = AXW'(a);
            end
        best_reg <= b;
        tb_reg   <= tb;
        c1_reg   <= ctx_reg[DL-1];
    end

    // Products t * dir, magnitudes first, one stage registered.
    logic [2*CW-1:0] prod_reg [NAX];
    logic            pneg_reg [NAX];
    logic [AXW-1:0]  best2_reg, best3_reg, best4_reg;
    logic            tneg2_reg, tneg3_reg, tneg4_reg;
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NAX; a++)
        begin
            logic [CW-1:0] x, y;
            x = tb_reg[CW-1] ? CW'(-tb_reg) : tb_reg;
            y = c1_reg.dir[a][CW-1] ? CW'(-c1_reg.dir[a]) : c1_reg.dir[a];
            prod_reg[a] <= x * y;
            pneg_reg[a] <= tb_reg[CW-1] ^ c1_reg.dir[a][CW-1];
        end
        best2_reg <= best_reg;
        tneg2_reg <= tb_reg[CW-1];
        c2_reg    <= c1_reg;
    end

    // Scale, round toward minus infinity and saturate the products.
    coord_t m_reg [NAX];
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NAX; a++)
        begin
            logic [2*CW-FB:0] q;
            logic [2*CW-FB:0] cap;
            q = (2*CW-FB+1)'(prod_reg[a] >> FB)
              + (2*CW-FB+1)'(pneg_reg[a] && prod_reg[a][FB-1:0] != '0);
            cap = pneg_reg[a] ? (2*CW-FB+1)'({1'b1, {(CW-1){1'b0}}})
                              : (2*CW-FB+1)'({1'b0, {(CW-1){1'b1}}});
            if (q > cap)
                q = cap;
            m_reg[a] <= pneg_reg[a] ? CW'(-q) : q[CW-1:0];
        end
        best3_reg <= best2_reg;
        tneg3_reg <= tneg2_reg;
        c3_reg    <= c2_reg;
    end

    // Saturating add of origin.
    coord_t v_reg [NAX];
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NAX; a++)
        begin
            logic signed [CW:0] s;
            s = {c3_reg.org[a][CW-1], c3_reg.org[a]} + {m_reg[a][CW-1], m_reg[a]};
            if (s > (CW+1)'(HI_LIM))
                v_reg[a] <= HI_LIM;
            else if (s < (CW+1)'(LO_LIM))
                v_reg[a] <= LO_LIM;
            else
                v_reg[a] <= s[CW-1:0];
        end
        best4_reg <= best3_reg;
        tneg4_reg <= tneg3_reg;
        c4_reg    <= c3_reg;
    end

    // Box test and result word.
    logic   done_reg, hit_reg;
    coord_t pt_reg [NAX];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        logic h;
        coord_t p [NAX];
        h = !tneg4_reg;
        for (int a = 0; a < NAX; a++)
        begin
            if (AXW'(a) == best4_reg)
                p[a] = c4_reg.plane[a];
            else
            begin
                p[a] = v_reg[a];
                if (v_reg[a] < c4_reg.lo[a] || v_reg[a] > c4_reg.hi[a])
                    h = 1'b0;
            end
        end
        if (c4_reg.in_box)
        begin
            hit_reg <= 1'b1;
            for (int a = 0; a < NAX; a++)
                pt_reg[a] <= c4_reg.org[a];
        end
        else
        begin
            hit_reg <= h;
            for (int a = 0; a < NAX; a++)
                pt_reg[a] <= h ? p[a] : '0;
        end
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign point_x = pt_reg[0];
    assign point_y = pt_reg[1];
    assign point_z = pt_reg[2];

`ifndef SYNTHESIS
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("core reported busy");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT-1] |=> done)
        else $error("result strobe lost");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (point_x == '0 && point_y == '0 && point_z == '0))
        else $error("miss with nonzero point");
`endif
endmodule
`default_nettype wire
